/* rtl/jes_pkg.sv */
// Package for the Jacobi eigenvalue solver: sizes, register indexes, fixed-point helpers.
// Used by jes_iter and jacobi_eigen_solver; depends on nothing else.
`timescale 1ns / 1ps

package jes_pkg;

	localparam int MAX_DIM   = 4;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int N_W       = $clog2(MAX_DIM + 1);
	localparam int LC_W      = $clog2(DEPTH + 1);

	localparam int DATA_W    = 32;
	localparam int OUT_IDX_W = 2;
	localparam int TDATA_W   = 40;
	localparam int SIZE_W    = 3;
	localparam int SWEEP_W   = 6;
	localparam int TOL_W     = 31;
	localparam int CFG_IDX_W = 2;

	localparam int MUL_W     = 34;
	localparam int PROD_W    = 64;
	localparam int QR_W      = 34;
	localparam int SUM_W     = 36;
	localparam int DEN_W     = 34;
	localparam int ITER_STEPS = 32;
	localparam int ITER_CNT_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEPS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;

	localparam logic [SIZE_W-1:0]  SIZE_RST  = 3'd4;
	localparam logic [SWEEP_W-1:0] SWEEP_RST = 6'd20;
	localparam logic [TOL_W-1:0]   TOL_RST   = '0;

	localparam logic signed [DATA_W-1:0] Q24_ONE = 32'sh0100_0000;
	localparam logic signed [SUM_W-1:0]  SAT_HI  = 36'sd2147483647;
	localparam logic signed [SUM_W-1:0]  SAT_LO  = -36'sd2147483648;

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_rsp_t;

	// Q2.30 times Q8.24 product brought back to Q8.24, halves rounded away from zero.
	function automatic logic signed [QR_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] m;
		logic [PROD_W-1:0] r;
		m = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
		r = (m + (PROD_W'(1) << 29)) >> 30;
		qround = p[PROD_W-1] ? -$signed(QR_W'(r)) : $signed(QR_W'(r));
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		if (x > SAT_HI) begin
			sat32 = SAT_HI[DATA_W-1:0];
		end else if (x < SAT_LO) begin
			sat32 = SAT_LO[DATA_W-1:0];
		end else begin
			sat32 = x[DATA_W-1:0];
		end
	endfunction

endpackage

/* rtl/jacobi_eigen_solver.sv */
// Top level of the cyclic Jacobi eigenvalue solver: load, identity fill, sweeps, emit.
// Depends on jes_pkg and jes_iter.
`timescale 1ns / 1ps
//
// Channel   Dir  Word
// s_*       in   tdata[31:0] element_value (Q8.24), row-major
// m_*       out  tuser = kind; tdata = row, col, value, converged; tlast = last of run
// cfg_*     in   cfg_index 0 matrix_size, 1 sweep_limit, 2 zero_tolerance
//
// Loading takes one element per cycle while s_tvalid is high; then a pass over every entry writes the identity store.
// Each rotation's cost is set by five passes through the shared one-bit-a-cycle
// root/divide unit and by the single read and single write port of each matrix memory.
// Each result word is read, loaded, then held until m_tready; no input is taken until the last goes.
// Reset clears control only; the matrix memory holds nothing defined until loaded.

module jacobi_eigen_solver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [jes_pkg::DATA_W-1:0]       s_tdata,   // [31:0] element_value
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [jes_pkg::TDATA_W-1:0]      m_tdata,   // [1:0] row, [3:2] col, [35:4] value, [36] converged
	output logic                             m_tuser,   // [0] kind
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [jes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jes_pkg::TOL_W-1:0]        cfg_wdata
);
	import jes_pkg::*;

	typedef enum logic [5:0] {
		S_LOAD, S_INIT, S_SWEEP_START, S_PAIR, S_CHK, S_GRR, S_GCC, S_GCR, S_DE,
		S_SHR, S_SHL, S_SQ1, S_SQ2, S_SQ3, S_WS, S_WD1, S_TT, S_TT2, S_WS2, S_WD2,
		S_SM1, S_SM2, S_WD3, S_U1, S_U2, S_U3, S_U4, S_U5,
		S_ILOOP, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8, S_I9,
		S_V, S_V1, S_V2, S_V3, S_V4, S_V5, S_V6,
		S_SWEEP_END, S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD
	} state_t;

	state_t state_q;

	// Configuration
	logic [SIZE_W-1:0]  size_q;
	logic [SWEEP_W-1:0] maxsw_q;
	logic [TOL_W-1:0]   tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RST;
			maxsw_q <= SWEEP_RST;
			tol_q   <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE:   size_q  <= cfg_wdata[SIZE_W-1:0];
				REG_SWEEPS: maxsw_q <= cfg_wdata[SWEEP_W-1:0];
				REG_TOL:    tol_q   <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	logic [N_W-1:0]  n_c;
	logic [LC_W-1:0] nn_c;
	always_comb begin
		if (size_q == '0) begin
			n_c = N_W'(1);
		end else if (32'(size_q) > MAX_DIM) begin
			n_c = N_W'(MAX_DIM);
		end else begin
			n_c = N_W'(size_q);
		end
		nn_c = LC_W'(32'(n_c) * 32'(n_c));
	end

	function automatic logic [ADDR_W-1:0] addr(input logic [N_W-1:0] row,
		input logic [N_W-1:0] col);
		addr = {row[IDX_W-1:0], col[IDX_W-1:0]};
	endfunction

	// Registers of the sequencer and datapath
	logic [LC_W-1:0]    lc_q;
	logic [ADDR_W:0]    init_q;
	logic [SWEEP_W-1:0] sweep_q;
	logic               diag_q;
	logic [N_W-1:0]     r_q, c_q, i_q;
	logic               kind_q;
	logic signed [DATA_W-1:0] arc_q, arr_q, acc_q, acr_q, aic_q, air_q;
	logic [DATA_W:0]    dm_q, em_q;
	logic               neg_q;
	logic [PROD_W-1:0]  sq_q;
	logic [DATA_W-1:0]  tm_q, cm_q, sm_q;
	logic signed [DATA_W-1:0] t_q, sn_q, tau_q, cs_q;
	logic signed [QR_W-1:0]   qa_q, x_q, y_q, p_q;
	logic signed [DATA_W-1:0] nc_q, nr_q;
	logic                m_tvalid_q;
	logic [TDATA_W-1:0]  m_tdata_q;
	logic                m_tuser_q, m_tlast_q;

	// Memories
	logic signed [DATA_W-1:0] wm [DEPTH];
	logic signed [DATA_W-1:0] vm [DEPTH];
	logic signed [DATA_W-1:0] wm_rd_q, vm_rd_q;
	logic                     wm_we, vm_we;
	logic [ADDR_W-1:0]        wm_waddr, wm_raddr, vm_waddr, vm_raddr;
	logic signed [DATA_W-1:0] wm_wdata, vm_wdata;

	always_ff @(posedge clk) begin
		if (wm_we) begin
			wm[wm_waddr] <= wm_wdata;
		end
		wm_rd_q <= wm[wm_raddr];
	end

	always_ff @(posedge clk) begin
		if (vm_we) begin
			vm[vm_waddr] <= vm_wdata;
		end
		vm_rd_q <= vm[vm_raddr];
	end

	// Shared multiplier, registered
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_q;
	logic signed [QR_W-1:0]   qr;
	always_ff @(posedge clk) begin
		mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end
	assign qr = qround(mul_q);

	// Iterative root / divide unit
	iter_req_t          ireq;
	iter_rsp_t          irsp;
	logic [PROD_W-1:0]  inum;
	logic [DEN_W-1:0]   iden;
	logic [DATA_W-1:0]  ires;

	jes_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.num    (inum),
		.den    (iden),
		.rsp    (irsp),
		.result (ires)
	);

	// Load position for the size in force now
	logic [LC_W-1:0] ld_cnt;
	logic [N_W-1:0]  ld_row, ld_col;
	logic [LC_W-1:0] ld_next;
	always_comb begin
		ld_cnt = (lc_q >= nn_c) ? '0 : lc_q;
		ld_row = '0;
		for (int k = 0; k < MAX_DIM; k++) begin
			if (32'(ld_cnt) >= k * 32'(n_c)) begin
				ld_row = N_W'(k);
			end
		end
		ld_col  = N_W'(32'(ld_cnt) - 32'(ld_row) * 32'(n_c));
		ld_next = ld_cnt + 1'b1;
	end

	logic [DATA_W:0]   dm_or;
	logic [DATA_W-1:0] arc_mag;
	logic [PROD_W-1:0] sm_sum;
	logic [N_W-1:0]    init_row, init_col;
	logic              emit_last;
	assign dm_or    = dm_q | em_q;
	assign arc_mag  = wm_rd_q[DATA_W-1] ? $unsigned(-wm_rd_q) : $unsigned(wm_rd_q);
	assign sm_sum   = $unsigned(mul_q) + (PROD_W'(1) << 29);
	assign init_row = N_W'(init_q[ADDR_W-1:IDX_W]);
	assign init_col = N_W'(init_q[IDX_W-1:0]);
	assign emit_last = kind_q && (r_q == n_c - 1'b1) && (c_q == n_c - 1'b1);

	always_comb begin
		wm_we    = 1'b0;
		wm_waddr = '0;
		wm_wdata = '0;
		wm_raddr = '0;
		vm_we    = 1'b0;
		vm_waddr = '0;
		vm_wdata = '0;
		vm_raddr = '0;
		mul_a    = '0;
		mul_b    = '0;
		ireq.start = 1'b0;
		ireq.op    = OP_SQRT;
		inum     = '0;
		iden     = '0;
		case (state_q)
			S_LOAD: begin
				wm_we    = s_tvalid;
				wm_waddr = addr(ld_row, ld_col);
				wm_wdata = s_tdata;
			end
			S_INIT: begin
				vm_we    = 1'b1;
				vm_waddr = init_q[ADDR_W-1:0];
				vm_wdata = (init_row == init_col) ? Q24_ONE : '0;
			end
			S_PAIR:  wm_raddr = addr(r_q, c_q);
			S_CHK:   wm_raddr = addr(r_q, r_q);
			S_GRR:   wm_raddr = addr(c_q, c_q);
			S_GCC:   wm_raddr = addr(c_q, r_q);
			S_SQ1: begin
				mul_a = MUL_W'(dm_q);
				mul_b = MUL_W'(dm_q);
			end
			S_SQ2: begin
				mul_a = MUL_W'(em_q);
				mul_b = MUL_W'(em_q);
			end
			S_SQ3: begin
				ireq.start = 1'b1;
				ireq.op    = OP_SQRT;
				inum       = sq_q + $unsigned(mul_q);
			end
			S_WS: begin
				ireq.start = irsp.done;
				ireq.op    = OP_DIV;
				inum       = PROD_W'(em_q) << 30;
				iden       = DEN_W'(dm_q) + DEN_W'(ires);
			end
			S_TT: begin
				mul_a = MUL_W'(tm_q);
				mul_b = MUL_W'(tm_q);
			end
			S_TT2: begin
				ireq.start = 1'b1;
				ireq.op    = OP_SQRT;
				inum       = $unsigned(mul_q) + (PROD_W'(1) << 60);
			end
			S_WS2: begin
				ireq.start = irsp.done;
				ireq.op    = OP_DIV;
				inum       = PROD_W'(1) << 60;
				iden       = DEN_W'(ires);
			end
			S_SM1: begin
				mul_a = MUL_W'(tm_q);
				mul_b = MUL_W'(cm_q);
			end
			S_SM2: begin
				ireq.start = 1'b1;
				ireq.op    = OP_DIV;
				inum       = PROD_W'(sm_sum[61:30]) << 30;
				iden       = (DEN_W'(1) << 30) + DEN_W'(cm_q);
			end
			S_U1: begin
				mul_a = MUL_W'(t_q);
				mul_b = MUL_W'(acr_q);
			end
			S_U2: begin
				wm_we    = 1'b1;
				wm_waddr = addr(r_q, r_q);
				wm_wdata = sat32(SUM_W'(arr_q) + SUM_W'(qr));
			end
			S_U3: begin
				wm_we    = 1'b1;
				wm_waddr = addr(c_q, c_q);
				wm_wdata = sat32(SUM_W'(acc_q) - SUM_W'(qa_q));
			end
			S_U4: begin
				wm_we    = 1'b1;
				wm_waddr = addr(r_q, c_q);
			end
			S_U5: begin
				wm_we    = 1'b1;
				wm_waddr = addr(c_q, r_q);
			end
			S_ILOOP: wm_raddr = addr(i_q, c_q);
			S_I1:    wm_raddr = addr(i_q, r_q);
			S_I3: begin
				mul_a = MUL_W'(tau_q);
				mul_b = MUL_W'(aic_q);
			end
			S_I4: begin
				mul_a = MUL_W'(tau_q);
				mul_b = MUL_W'(air_q);
			end
			S_I5: begin
				mul_a = MUL_W'(sn_q);
				mul_b = x_q;
			end
			S_I6: begin
				mul_a    = MUL_W'(sn_q);
				mul_b    = y_q;
				wm_we    = 1'b1;
				wm_waddr = addr(i_q, c_q);
				wm_wdata = sat32(SUM_W'(aic_q) - SUM_W'(qr));
			end
			S_I7: begin
				wm_we    = 1'b1;
				wm_waddr = addr(i_q, r_q);
				wm_wdata = sat32(SUM_W'(air_q) + SUM_W'(qr));
			end
			S_I8: begin
				wm_we    = 1'b1;
				wm_waddr = addr(c_q, i_q);
				wm_wdata = nc_q;
			end
			S_I9: begin
				wm_we    = 1'b1;
				wm_waddr = addr(r_q, i_q);
				wm_wdata = nr_q;
			end
			S_V:  vm_raddr = addr(i_q, c_q);
			S_V1: vm_raddr = addr(i_q, r_q);
			S_V2: begin
				mul_a = MUL_W'(cs_q);
				mul_b = MUL_W'(aic_q);
			end
			S_V3: begin
				mul_a = MUL_W'(sn_q);
				mul_b = MUL_W'(air_q);
			end
			S_V4: begin
				mul_a    = MUL_W'(sn_q);
				mul_b    = MUL_W'(aic_q);
				vm_we    = 1'b1;
				vm_waddr = addr(i_q, c_q);
				vm_wdata = sat32(SUM_W'(p_q) - SUM_W'(qr));
			end
			S_V5: begin
				mul_a = MUL_W'(cs_q);
				mul_b = MUL_W'(air_q);
			end
			S_V6: begin
				vm_we    = 1'b1;
				vm_waddr = addr(i_q, r_q);
				vm_wdata = sat32(SUM_W'(p_q) + SUM_W'(qr));
			end
			S_EMIT_RD: begin
				wm_raddr = addr(r_q, c_q);
				vm_raddr = addr(r_q, c_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			lc_q       <= '0;
			init_q     <= '0;
			sweep_q    <= '0;
			diag_q     <= 1'b0;
			r_q        <= '0;
			c_q        <= '0;
			i_q        <= '0;
			kind_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (s_tvalid) begin
						if (ld_next == nn_c) begin
							lc_q    <= '0;
							init_q  <= '0;
							state_q <= S_INIT;
						end else begin
							lc_q <= ld_next;
						end
					end
				end
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (ADDR_W+1)'(DEPTH - 1)) begin
						sweep_q <= '0;
						if (maxsw_q == '0) begin
							diag_q  <= 1'b0;
							r_q     <= '0;
							c_q     <= '0;
							kind_q  <= 1'b0;
							state_q <= S_EMIT_RD;
						end else begin
							state_q <= S_SWEEP_START;
						end
					end
				end
				S_SWEEP_START: begin
					diag_q  <= 1'b1;
					r_q     <= '0;
					c_q     <= N_W'(1);
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					if (c_q < n_c) begin
						state_q <= S_CHK;
					end else if (({1'b0, r_q} + 2'd2) < {1'b0, n_c}) begin
						r_q <= r_q + 1'b1;
						c_q <= r_q + N_W'(2);
					end else begin
						state_q <= S_SWEEP_END;
					end
				end
				S_CHK: begin
					if (arc_mag > {1'b0, tol_q}) begin
						diag_q  <= 1'b0;
						arc_q   <= wm_rd_q;
						state_q <= S_GRR;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_PAIR;
					end
				end
				S_GRR: begin
					arr_q   <= wm_rd_q;
					state_q <= S_GCC;
				end
				S_GCC: begin
					acc_q   <= wm_rd_q;
					state_q <= S_GCR;
				end
				S_GCR: begin
					acr_q   <= wm_rd_q;
					state_q <= S_DE;
				end
				S_DE: begin
					logic signed [DATA_W:0] d, e;
					d = (DATA_W+1)'(arr_q) - (DATA_W+1)'(acc_q);
					e = {arc_q, 1'b0};
					neg_q <= (d != '0) && (d[DATA_W] != e[DATA_W]);
					dm_q  <= d[DATA_W] ? $unsigned(-d) : $unsigned(d);
					em_q  <= e[DATA_W] ? $unsigned(-e) : $unsigned(e);
					state_q <= S_SHR;
				end
				S_SHR: begin
					if (|dm_or[DATA_W:DATA_W-1]) begin
						dm_q <= dm_q >> 1;
						em_q <= em_q >> 1;
					end else if (dm_or == '0) begin
						tm_q    <= '0;
						state_q <= S_TT;
					end else begin
						state_q <= S_SHL;
					end
				end
				S_SHL: begin
					// Normalize so the larger magnitude has bit 30 set.
					if (!(|dm_or[DATA_W:DATA_W-2])) begin
						dm_q <= dm_q << 1;
						em_q <= em_q << 1;
					end else begin
						state_q <= S_SQ1;
					end
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: begin
					sq_q    <= $unsigned(mul_q);
					state_q <= S_SQ3;
				end
				S_SQ3: state_q <= S_WS;
				S_WS: begin
					if (irsp.done) begin
						state_q <= S_WD1;
					end
				end
				S_WD1: begin
					if (irsp.done) begin
						tm_q    <= ires;
						state_q <= S_TT;
					end
				end
				S_TT:  state_q <= S_TT2;
				S_TT2: state_q <= S_WS2;
				S_WS2: begin
					if (irsp.done) begin
						state_q <= S_WD2;
					end
				end
				S_WD2: begin
					if (irsp.done) begin
						cm_q    <= ires;
						state_q <= S_SM1;
					end
				end
				S_SM1: state_q <= S_SM2;
				S_SM2: begin
					sm_q    <= sm_sum[61:30];
					state_q <= S_WD3;
				end
				S_WD3: begin
					if (irsp.done) begin
						t_q     <= neg_q ? -$signed(tm_q) : $signed(tm_q);
						sn_q    <= neg_q ? -$signed(sm_q) : $signed(sm_q);
						tau_q   <= neg_q ? -$signed(ires) : $signed(ires);
						cs_q    <= $signed(cm_q);
						state_q <= S_U1;
					end
				end
				S_U1: state_q <= S_U2;
				S_U2: begin
					qa_q    <= qr;
					state_q <= S_U3;
				end
				S_U3: state_q <= S_U4;
				S_U4: state_q <= S_U5;
				S_U5: begin
					i_q     <= '0;
					state_q <= S_ILOOP;
				end
				S_ILOOP: begin
					if (i_q >= n_c) begin
						i_q     <= '0;
						state_q <= S_V;
					end else if (i_q == r_q || i_q == c_q) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_I1;
					end
				end
				S_I1: begin
					aic_q   <= wm_rd_q;
					state_q <= S_I2;
				end
				S_I2: begin
					air_q   <= wm_rd_q;
					state_q <= S_I3;
				end
				S_I3: state_q <= S_I4;
				S_I4: begin
					x_q     <= QR_W'(SUM_W'(air_q) + SUM_W'(qr));
					state_q <= S_I5;
				end
				S_I5: begin
					y_q     <= QR_W'(SUM_W'(aic_q) - SUM_W'(qr));
					state_q <= S_I6;
				end
				S_I6: begin
					nc_q    <= sat32(SUM_W'(aic_q) - SUM_W'(qr));
					state_q <= S_I7;
				end
				S_I7: begin
					nr_q    <= sat32(SUM_W'(air_q) + SUM_W'(qr));
					state_q <= S_I8;
				end
				S_I8: state_q <= S_I9;
				S_I9: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_ILOOP;
				end
				S_V: begin
					if (i_q >= n_c) begin
						c_q     <= c_q + 1'b1;
						state_q <= S_PAIR;
					end else begin
						state_q <= S_V1;
					end
				end
				S_V1: begin
					aic_q   <= vm_rd_q;
					state_q <= S_V2;
				end
				S_V2: begin
					air_q   <= vm_rd_q;
					state_q <= S_V3;
				end
				S_V3: begin
					p_q     <= qr;
					state_q <= S_V4;
				end
				S_V4: state_q <= S_V5;
				S_V5: begin
					p_q     <= qr;
					state_q <= S_V6;
				end
				S_V6: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_V;
				end
				S_SWEEP_END: begin
					sweep_q <= sweep_q + 1'b1;
					if (!diag_q && ({1'b0, sweep_q} + 1'b1) < {1'b0, maxsw_q}) begin
						state_q <= S_SWEEP_START;
					end else begin
						r_q     <= '0;
						c_q     <= '0;
						kind_q  <= 1'b0;
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_LD;
				S_EMIT_LD: begin
					m_tvalid_q <= 1'b1;
					m_tuser_q  <= kind_q;
					m_tlast_q  <= emit_last;
					m_tdata_q  <= {(TDATA_W-DATA_W-2*OUT_IDX_W-1)'(0), diag_q,
						kind_q ? vm_rd_q : wm_rd_q,
						c_q[OUT_IDX_W-1:0], r_q[OUT_IDX_W-1:0]};
					state_q    <= S_EMIT_HOLD;
				end
				S_EMIT_HOLD: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_EMIT_RD;
							if (c_q + 1'b1 < n_c) begin
								c_q <= c_q + 1'b1;
							end else begin
								c_q <= '0;
								if (r_q + 1'b1 < n_c) begin
									r_q <= r_q + 1'b1;
								end else begin
									r_q    <= '0;
									kind_q <= 1'b1;
								end
							end
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign s_tready = (state_q == S_LOAD);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken while a result is pending");
	a_last_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("block did not return to loading after the last word");
	a_iter_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ireq.start |-> !irsp.busy) else $error("iterative unit restarted while busy");
`endif

endmodule

/* rtl/jes_iter.sv */
// Shared iterative unit: 64-bit integer square root or 64/34-bit division, one bit a cycle.
// Depends on jes_pkg.
`timescale 1ns / 1ps

module jes_iter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jes_pkg::iter_req_t             req,
	input  logic [jes_pkg::PROD_W-1:0]     num,
	input  logic [jes_pkg::DEN_W-1:0]      den,
	output jes_pkg::iter_rsp_t             rsp,
	output logic [jes_pkg::DATA_W-1:0]     result
);
	import jes_pkg::*;

	logic [PROD_W-1:0]     acc_q;
	logic [PROD_W:0]       aux_q;
	logic [PROD_W-1:0]     res_q;
	logic [ITER_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	iter_op_t              op_q;

	logic [PROD_W-1:0] trial;
	assign trial = res_q + aux_q[PROD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
				acc_q  <= num;
				res_q  <= '0;
				if (req.op == OP_SQRT) begin
					aux_q <= (PROD_W+1)'(1) << 62;
				end else begin
					aux_q <= (PROD_W+1)'(den) << (ITER_STEPS - 1);
				end
			end else if (busy_q) begin
				if (op_q == OP_SQRT) begin
					// Classic digit-by-digit root: aux holds the current power of four.
					if (acc_q >= trial) begin
						acc_q <= acc_q - trial;
						res_q <= (res_q >> 1) + aux_q[PROD_W-1:0];
					end else begin
						res_q <= res_q >> 1;
					end
					aux_q <= aux_q >> 2;
				end else begin
					if ({1'b0, acc_q} >= aux_q) begin
						acc_q <= acc_q - aux_q[PROD_W-1:0];
						res_q <= {res_q[PROD_W-2:0], 1'b1};
					end else begin
						res_q <= {res_q[PROD_W-2:0], 1'b0};
					end
					aux_q <= aux_q >> 1;
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_CNT_W'(ITER_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = res_q[DATA_W-1:0];

`ifndef SYNTHESIS
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("iter: done while busy");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("iter: start did not raise busy");
	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("iter: done without work");
`endif

endmodule
